// ===== sv/twia_pkg.sv =====
// Package for the typed-width integer ALU: transaction structs, operation and
// status codes, the width-fit function and the divider pipeline types.
// No dependencies; every other file in sv/ imports it.
`timescale 1ns / 1ps

package twia_pkg;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_REM = 3'd4;
  localparam logic [2:0] OP_NEG = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MIXED   = 2'd1;
  localparam logic [1:0] ST_DIVZERO = 2'd2;

  // Element type: bits [2:1] select the width, bit 0 set means unsigned.
  localparam logic [1:0] WID_8  = 2'd0;
  localparam logic [1:0] WID_16 = 2'd1;
  localparam logic [1:0] WID_32 = 2'd2;
  localparam logic [1:0] WID_64 = 2'd3;

  localparam int DivSteps = 64;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [63:0] operand_a;
    logic signed [63:0] operand_b;
    logic [2:0]         type_a;
    logic [2:0]         type_b;
  } cmd_t;

  typedef struct packed {
    logic signed [63:0] result;
    logic [1:0]         status;
  } rsp_t;

  // What travels beside the divider: everything the final stage needs.
  typedef struct packed {
    logic [2:0]  op;
    logic [2:0]  typ;
    logic [1:0]  status;
    logic [63:0] value;
    logic        neg_q;
    logic        neg_r;
  } side_t;

  typedef struct packed {
    logic [63:0] num;
    logic [63:0] den;
    side_t       side;
  } div_req_t;

  typedef struct packed {
    logic [63:0] quo;
    logic [63:0] rem;
    side_t       side;
  } div_rsp_t;

  // Cut a value to the type's width, then sign- or zero-extend it.
  function automatic logic [63:0] fit(input logic [63:0] v, input logic [2:0] t);
    logic [63:0] r;
    case (t[2:1])
      WID_8:   r = t[0] ? {56'd0, v[7:0]}  : {{56{v[7]}}, v[7:0]};
      WID_16:  r = t[0] ? {48'd0, v[15:0]} : {{48{v[15]}}, v[15:0]};
      WID_32:  r = t[0] ? {32'd0, v[31:0]} : {{32{v[31]}}, v[31:0]};
      WID_64:  r = v;
      default: r = v;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/twia_div.sv =====
// Pipelined unsigned restoring divider for the typed-width integer ALU:
// one quotient bit per register stage, side data carried alongside.
// Depends on twia_pkg.
`timescale 1ns / 1ps

module twia_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  twia_pkg::div_req_t  req,
  output logic                out_valid,
  output twia_pkg::div_rsp_t  rsp
);
  import twia_pkg::*;

  logic        vld  [DivSteps];
  logic [63:0] num  [DivSteps];
  logic [63:0] remr [DivSteps];
  logic [63:0] den  [DivSteps];
  side_t       side [DivSteps];

  // The dividend shifts out of num at the top while quotient bits fill the bottom.
  function automatic logic [127:0] div_step(input logic [63:0] r, input logic [63:0] n,
                                            input logic [63:0] d);
    logic [64:0] wide;
    logic [63:0] nq;
    logic [63:0] rq;
    wide = {r, n[63]};
    nq   = {n[62:0], 1'b0};
    if (wide >= {1'b0, d}) begin
      rq    = 64'(wide - {1'b0, d});
      nq[0] = 1'b1;
    end else begin
      rq = wide[63:0];
    end
    return {rq, nq};
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DivSteps; k++) begin
        vld[k] <= 1'b0;
      end
    end else begin
      vld[0] <= in_valid;
      for (int k = 1; k < DivSteps; k++) begin
        vld[k] <= vld[k-1];
      end
    end
    {remr[0], num[0]} <= div_step(64'd0, req.num, req.den);
    den[0]  <= req.den;
    side[0] <= req.side;
    for (int k = 1; k < DivSteps; k++) begin
      {remr[k], num[k]} <= div_step(remr[k-1], num[k-1], den[k-1]);
      den[k]  <= den[k-1];
      side[k] <= side[k-1];
    end
  end

  assign out_valid = vld[DivSteps-1];
  assign rsp.quo   = num[DivSteps-1];
  assign rsp.rem   = remr[DivSteps-1];
  assign rsp.side  = side[DivSteps-1];

endmodule

// ===== sv/typed_width_integer_alu_core.sv =====
// Top level of the typed-width integer ALU: operand fit, split multiplier,
// sign handling around the pipelined divider, and the result register.
// Depends on twia_pkg and twia_div.
`timescale 1ns / 1ps

// Usage:
// A transaction is accepted at a rising edge where start is high and busy is
// low. busy is high only while rst is asserted, so outside reset one
// transaction can be accepted every cycle, back to back.
// cmd carries op, the two raw 64-bit operands and the two element types.
// Every accepted transaction produces exactly one result: done is high for
// one cycle while rsp holds result and status, and the receiver must take it
// in that cycle; there is no backpressure.
// Every operation passes the command register, the operand register, the
// divider and the result register, in that order. The divider resolves one
// quotient bit per pipeline stage over 64 stages; add, sub, mul and neg ride
// along beside it so that results leave in order.
// Throughput is one transaction per cycle.
// A synchronous reset flushes every valid bit in the pipeline; transactions
// in flight are dropped and no done pulse follows for them.
module typed_width_integer_alu_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  twia_pkg::cmd_t   cmd,
  output logic             done,
  output twia_pkg::rsp_t   rsp
);
  import twia_pkg::*;

  logic        v1;
  cmd_t        cmd1;

  logic        v2;
  logic [63:0] a2;
  logic [63:0] b2;
  logic [63:0] p0;
  logic [31:0] p1;
  logic [31:0] p2;
  logic [2:0]  op2;
  logic [2:0]  typ2;
  logic [1:0]  st2;

  logic [63:0] a_fit;
  logic [63:0] b_fit;
  logic [1:0]  st_next;

  logic [63:0] value_next;
  logic        sgn;
  logic        neg_a;
  logic        neg_b;
  div_req_t    req;

  logic        div_valid;
  div_rsp_t    drsp;
  logic [63:0] quo_s;
  logic [63:0] rem_s;
  logic [63:0] final_val;

  assign busy = rst;

  // Stage 1: capture the command.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
    cmd1 <= cmd;
  end

  // Stage 2: fit operands, classify errors, start the partial products.
  always_comb begin
    a_fit = fit(cmd1.operand_a, cmd1.type_a);
    b_fit = fit(cmd1.operand_b, cmd1.type_a);
    if (cmd1.op >= OP_NEG) begin
      st_next = ST_OK;
    end else if (cmd1.type_a != cmd1.type_b) begin
      st_next = ST_MIXED;
    end else if ((cmd1.op == OP_DIV || cmd1.op == OP_REM) && b_fit == 64'd0) begin
      st_next = ST_DIVZERO;
    end else begin
      st_next = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    a2   <= a_fit;
    b2   <= b_fit;
    p0   <= 64'(a_fit[31:0]) * 64'(b_fit[31:0]);
    p1   <= 32'(a_fit[31:0] * b_fit[63:32]);
    p2   <= 32'(a_fit[63:32] * b_fit[31:0]);
    op2  <= cmd1.op;
    typ2 <= cmd1.type_a;
    st2  <= st_next;
  end

  // Stage 3: wrap arithmetic, and magnitudes and signs for the divider.
  always_comb begin
    case (op2)
      OP_ADD:  value_next = a2 + b2;
      OP_SUB:  value_next = a2 - b2;
      OP_MUL:  value_next = p0 + {p1 + p2, 32'd0};
      OP_NEG:  value_next = 64'd0 - a2;
      default: value_next = 64'd0;
    endcase
    sgn   = !typ2[0];
    neg_a = sgn && a2[63];
    neg_b = sgn && b2[63];
    req.num        = neg_a ? 64'd0 - a2 : a2;
    req.den        = neg_b ? 64'd0 - b2 : b2;
    req.side.op    = op2;
    req.side.typ   = typ2;
    req.side.status = st2;
    req.side.value = value_next;
    req.side.neg_q = neg_a ^ neg_b;
    req.side.neg_r = neg_a;
  end

  twia_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2),
    .req       (req),
    .out_valid (div_valid),
    .rsp       (drsp)
  );

  // Final stage: restore signs, select, fit to the type, zero on error.
  always_comb begin
    quo_s = drsp.side.neg_q ? 64'd0 - drsp.quo : drsp.quo;
    rem_s = drsp.side.neg_r ? 64'd0 - drsp.rem : drsp.rem;
    case (drsp.side.op)
      OP_DIV:  final_val = quo_s;
      OP_REM:  final_val = rem_s;
      default: final_val = drsp.side.value;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= div_valid;
    end
    rsp.status <= drsp.side.status;
    rsp.result <= (drsp.side.status != ST_OK) ? 64'd0 : fit(final_val, drsp.side.typ);
  end

endmodule

// ===== sv/twia_checker.sv =====
// Port-level checker for the typed-width integer ALU, bound to the top level.
// Depends on twia_pkg and typed_width_integer_alu_core.
`timescale 1ns / 1ps

module twia_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           done,
  input twia_pkg::rsp_t rsp
);
  import twia_pkg::*;

  // Every accepted transaction comes out after the fixed latency.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##67 done)
    else $error("accepted transaction produced no result");

  // No result appears without a transaction accepted at that distance.
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 67))
    else $error("result without a matching transaction");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (rsp.status == ST_OK || rsp.status == ST_MIXED || rsp.status == ST_DIVZERO))
    else $error("undefined status code");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status != ST_OK) |-> (rsp.result == 64'sd0))
    else $error("error result is not zero");

endmodule

bind typed_width_integer_alu_core twia_checker u_twia_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);
